>>> rtl/sbce_pkg.sv
// sbce_pkg: shared types and constants of the 16-bit execute block
// opcode, status and request codes, controller states and the
// command/status structs between controller and datapath
package sbce_pkg;

    localparam int MEM_WORDS_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [15:0] SP_BASE = 16'h8200;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_EXEC = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HALT      = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_UNDEFINED = 3'd4,
        ST_STOPPED   = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        OP_SYS  = 5'h00,
        OP_JMP  = 5'h01,
        OP_MOVR = 5'h02,
        OP_MOVI = 5'h03,
        OP_STRR = 5'h04,
        OP_STRI = 5'h05,
        OP_LDR  = 5'h06,
        OP_ADD  = 5'h08,
        OP_SUB  = 5'h0A,
        OP_MUL  = 5'h0C,
        OP_AND  = 5'h0E,
        OP_ORR  = 5'h10,
        OP_NOT  = 5'h12,
        OP_XOR  = 5'h14,
        OP_SHR  = 5'h16,
        OP_SHL  = 5'h18,
        OP_ROR  = 5'h1A,
        OP_ROL  = 5'h1C,
        OP_HALT = 5'h1F
    } opcode_t;

    // suffix of the system group, also the jump condition
    typedef enum logic [1:0] {
        SFX_NOP = 2'd0,
        SFX_PSH = 2'd1,
        SFX_POP = 2'd2,
        SFX_CMP = 2'd3
    } suffix_t;

    typedef enum logic [1:0] {
        JC_ALWAYS = 2'd0,
        JC_EQ     = 2'd1,
        JC_LT     = 2'd2,
        JC_GT     = 2'd3
    } jcond_t;

    typedef enum logic [0:0] {
        CFG_START = 1'b0,
        CFG_END   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECODE,
        S_EXEC,
        S_LOADW,
        S_MULFIN
    } state_t;

    typedef enum logic [1:0] {
        RD_INPUT,
        RD_PC,
        RD_OPERAND
    } rd_sel_t;

    typedef enum logic [1:0] {
        OUT_PLAIN,
        OUT_READ,
        OUT_STOPPED,
        OUT_EXEC
    } out_sel_t;

    typedef struct packed {
        logic     clear;
        logic     load_wr;
        logic     mem_rd;
        rd_sel_t  rd_sel;
        logic     decode;
        logic     prod_load;
        logic     commit;
        logic     out_load;
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic stop_now;
        logic is_ldr;
        logic is_mul;
    } dp_status_t;

endpackage

>>> rtl/sbce_ctrl.sv
// sbce_ctrl: sequencing state machine of the execute block
// drives datapath commands and the handshakes; depends on sbce_pkg
module sbce_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sbce_pkg::dp_status_t   dstat,
    output sbce_pkg::ctrl_cmd_t    cmd
);

    sbce_pkg::state_t state_reg;
    sbce_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == sbce_pkg::S_IDLE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbce_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbce_pkg::S_CLEAR:
            begin
                if (dstat.clr_last)
                    state_next = sbce_pkg::S_IDLE;
            end
            sbce_pkg::S_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    unique case (sbce_pkg::req_t'(req_type))
                        sbce_pkg::REQ_READ: state_next = sbce_pkg::S_READ;
                        sbce_pkg::REQ_EXEC:
                        begin
                            if (!dstat.stop_now)
                                state_next = sbce_pkg::S_DECODE;
                        end
                        default: state_next = sbce_pkg::S_IDLE;
                    endcase
                end
            end
            sbce_pkg::S_READ:
            begin
                if (out_free)
                    state_next = sbce_pkg::S_IDLE;
            end
            sbce_pkg::S_DECODE: state_next = sbce_pkg::S_EXEC;
            sbce_pkg::S_EXEC:
            begin
                if (dstat.is_ldr)
                    state_next = sbce_pkg::S_LOADW;
                else if (dstat.is_mul)
                    state_next = sbce_pkg::S_MULFIN;
                else if (out_free)
                    state_next = sbce_pkg::S_IDLE;
            end
            sbce_pkg::S_LOADW, sbce_pkg::S_MULFIN:
            begin
                if (out_free)
                    state_next = sbce_pkg::S_IDLE;
            end
            default: state_next = sbce_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        cmd.rd_sel  = sbce_pkg::RD_INPUT;
        cmd.out_sel = sbce_pkg::OUT_PLAIN;
        unique case (state_reg)
            sbce_pkg::S_CLEAR: cmd.clear = 1'b1;
            sbce_pkg::S_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    unique case (sbce_pkg::req_t'(req_type))
                        sbce_pkg::REQ_LOAD:
                        begin
                            cmd.load_wr  = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        sbce_pkg::REQ_READ:
                        begin
                            cmd.mem_rd = 1'b1;
                            cmd.rd_sel = sbce_pkg::RD_INPUT;
                        end
                        sbce_pkg::REQ_EXEC:
                        begin
                            if (dstat.stop_now)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = sbce_pkg::OUT_STOPPED;
                            end
                            else
                            begin
                                cmd.mem_rd = 1'b1;
                                cmd.rd_sel = sbce_pkg::RD_PC;
                            end
                        end
                        default: cmd.out_load = 1'b1;
                    endcase
                end
            end
            sbce_pkg::S_READ:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sbce_pkg::OUT_READ;
                end
            end
            sbce_pkg::S_DECODE: cmd.decode = 1'b1;
            sbce_pkg::S_EXEC:
            begin
                if (dstat.is_ldr)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = sbce_pkg::RD_OPERAND;
                end
                else if (dstat.is_mul)
                    cmd.prod_load = 1'b1;
                else if (out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sbce_pkg::OUT_EXEC;
                end
            end
            sbce_pkg::S_LOADW, sbce_pkg::S_MULFIN:
            begin
                if (out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sbce_pkg::OUT_EXEC;
                end
            end
            default: cmd.out_load = 1'b0;
        endcase
    end

endmodule

>>> rtl/sbce_dpath.sv
// sbce_dpath: datapath of the execute block: word memory, register file,
// stack, flags, program counter, alu and result registers; depends on sbce_pkg
module sbce_dpath #(
    parameter int MEM_WORDS   = sbce_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = sbce_pkg::STACK_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbce_pkg::ctrl_cmd_t   cmd,
    output sbce_pkg::dp_status_t  dstat,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [15:0]           address,
    input  logic [15:0]           value,
    output logic [15:0]           pc,
    output logic [15:0]           instruction,
    output logic [2:0]            status,
    output logic                  reg_write,
    output logic [2:0]            reg_index,
    output logic [15:0]           reg_value,
    output logic [3:0]            flags,
    output logic [15:0]           stack_pointer,
    output logic [15:0]           read_data
);

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SDW = $clog2(STACK_DEPTH + 1);
    localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);
    localparam logic [SDW-1:0] STACK_FULL = SDW'(STACK_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

    logic [15:0]     mem [MEM_WORDS];
    logic [15:0]     rd_data_reg;
    logic            rd_ok_reg;
    logic [15:0]     mem_data;
    logic [15:0]     rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic [AW-1:0]   clr_cnt_reg;

    logic [15:0]     rf_reg [8];
    logic [15:0]     p1_reg;
    logic [15:0]     p2_reg;
    logic [15:0]     instr_reg;
    logic [31:0]     prod_reg;
    logic [15:0]     pc_reg;
    logic [15:0]     end_reg;
    logic [3:0]      flags_reg;
    logic            stopped_reg;
    logic [SDW-1:0]  depth_reg;
    logic [SDW-1:0]  depth_next;
    logic [15:0]     stack_mem [STACK_DEPTH];
    logic [15:0]     top_reg;

    sbce_pkg::opcode_t dec_op;
    logic              dec_uses_ra;
    logic [2:0]        sel1;
    logic [2:0]        sel2;

    sbce_pkg::opcode_t op;
    logic [1:0]        sfx;
    logic [2:0]        ra;
    sbce_pkg::status_t ex_status;
    logic              ex_wr;
    logic [15:0]       ex_wval;
    logic [3:0]        ex_flags;
    logic [15:0]       ex_next;
    logic              ex_push;
    logic              ex_pop;
    logic              ex_store;
    logic [15:0]       ex_st_data;

    logic [16:0]       add_full;
    logic              add_c;
    logic [15:0]       add_r;
    logic              add_ov;
    logic              mul_c;
    logic [15:0]       mul_r;
    logic [15:0]       cmp_d;
    logic [15:0]       jmp_off;
    logic              jmp_take;
    logic [4:0]        sh;

    // ---------------- word memory
    assign mem_data = rd_ok_reg ? rd_data_reg : 16'h0000;

    always_comb
    begin
        case (cmd.rd_sel)
            sbce_pkg::RD_PC:      rd_addr = pc_reg;
            sbce_pkg::RD_OPERAND: rd_addr = p1_reg;
            default:              rd_addr = address;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
            rd_ok_reg   <= {1'b0, rd_addr} < MEM_LIMIT;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = address[AW-1:0];
        mem_wdata = value;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 16'h0000;
        end
        else if (cmd.load_wr)
        begin
            mem_we = {1'b0, address} < MEM_LIMIT;
        end
        else if (cmd.commit && ex_store && ex_status == sbce_pkg::ST_OK)
        begin
            mem_we    = {1'b0, p1_reg} < MEM_LIMIT;
            mem_waddr = p1_reg[AW-1:0];
            mem_wdata = ex_st_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // ---------------- decode: pick the two register read ports
    assign dec_op = sbce_pkg::opcode_t'(mem_data[15:11]);

    always_comb
    begin
        case (dec_op)
            sbce_pkg::OP_SYS, sbce_pkg::OP_STRR, sbce_pkg::OP_STRI: dec_uses_ra = 1'b1;
            default: dec_uses_ra = 1'b0;
        endcase
    end

    assign sel1 = dec_uses_ra ? mem_data[10:8] : mem_data[7:5];
    assign sel2 = dec_uses_ra ? mem_data[7:5]  : mem_data[4:2];

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            instr_reg <= mem_data;
            p1_reg    <= rf_reg[sel1];
            p2_reg    <= rf_reg[sel2];
        end
        if (cmd.prod_load)
            prod_reg <= p1_reg * p2_reg;
    end

    // ---------------- stack: top of stack re-read every cycle
    always_ff @(posedge clk)
    begin
        top_reg <= stack_mem[SAW'(depth_reg - 1'b1)];
        if (cmd.commit && ex_push && ex_status == sbce_pkg::ST_OK)
            stack_mem[SAW'(depth_reg)] <= p1_reg;
    end

    // ---------------- execute
    assign op  = sbce_pkg::opcode_t'(instr_reg[15:11]);
    assign sfx = instr_reg[1:0];
    assign ra  = instr_reg[10:8];
    assign sh  = instr_reg[4:0];

    assign add_full = {1'b0, p1_reg} + {1'b0, p2_reg};
    assign add_c    = add_full[16];
    assign add_r    = add_c ? (16'h0000 - add_full[15:0]) : add_full[15:0];
    // signed overflow judged on the original operands
    assign add_ov   = ((p1_reg != 16'h0000) && !p1_reg[15] && (p2_reg != 16'h0000)
                       && !p2_reg[15] && add_r[15])
                    || (p1_reg[15] && p2_reg[15] && !add_r[15]);
    assign mul_c    = |prod_reg[31:16];
    assign mul_r    = mul_c ? (16'h0000 - prod_reg[15:0]) : prod_reg[15:0];
    assign cmp_d    = p1_reg - p2_reg;
    assign jmp_off  = {{6{instr_reg[10]}}, instr_reg[10:2], 1'b0};

    always_comb
    begin
        case (sbce_pkg::jcond_t'(sfx))
            sbce_pkg::JC_ALWAYS: jmp_take = 1'b1;
            sbce_pkg::JC_EQ:     jmp_take = flags_reg[1] && !flags_reg[0];
            sbce_pkg::JC_LT:     jmp_take = !flags_reg[1] && flags_reg[0];
            default:             jmp_take = !flags_reg[1] && !flags_reg[0];
        endcase
    end

    always_comb
    begin
        ex_status  = sbce_pkg::ST_OK;
        ex_wr      = 1'b0;
        ex_wval    = 16'h0000;
        ex_flags   = flags_reg;
        ex_next    = pc_reg + 16'd2;
        ex_push    = 1'b0;
        ex_pop     = 1'b0;
        ex_store   = 1'b0;
        ex_st_data = p2_reg;
        unique case (op)
            sbce_pkg::OP_SYS:
            begin
                unique case (sbce_pkg::suffix_t'(sfx))
                    sbce_pkg::SFX_PSH:
                    begin
                        if (depth_reg >= STACK_FULL)
                            ex_status = sbce_pkg::ST_OVERFLOW;
                        else
                            ex_push = 1'b1;
                    end
                    sbce_pkg::SFX_POP:
                    begin
                        if (depth_reg == '0)
                            ex_status = sbce_pkg::ST_UNDERFLOW;
                        else
                        begin
                            ex_pop  = 1'b1;
                            ex_wr   = 1'b1;
                            ex_wval = top_reg;
                        end
                    end
                    sbce_pkg::SFX_CMP:
                        ex_flags = {p1_reg < p2_reg, 1'b0, p1_reg == p2_reg, cmp_d[15]};
                    default: ex_flags = flags_reg;
                endcase
            end
            sbce_pkg::OP_JMP:
            begin
                if (jmp_take)
                    ex_next = pc_reg + 16'd2 + jmp_off;
            end
            sbce_pkg::OP_MOVR:
            begin
                ex_wr   = 1'b1;
                ex_wval = p1_reg;
            end
            sbce_pkg::OP_MOVI:
            begin
                ex_wr   = 1'b1;
                ex_wval = {8'h00, instr_reg[7:0]};
            end
            sbce_pkg::OP_STRR: ex_store = 1'b1;
            sbce_pkg::OP_STRI:
            begin
                ex_store   = 1'b1;
                ex_st_data = {8'h00, instr_reg[7:0]};
            end
            sbce_pkg::OP_LDR:
            begin
                ex_wr   = 1'b1;
                ex_wval = mem_data;
            end
            sbce_pkg::OP_ADD:
            begin
                ex_wr    = 1'b1;
                ex_wval  = add_r;
                ex_flags = {add_c, add_ov, add_r == 16'h0000, add_r[15]};
            end
            sbce_pkg::OP_MUL:
            begin
                ex_wr    = 1'b1;
                ex_wval  = mul_r;
                ex_flags = {mul_c, mul_c, mul_r == 16'h0000, mul_r[15]};
            end
            sbce_pkg::OP_SUB:
            begin
                ex_wr   = 1'b1;
                ex_wval = cmp_d;
            end
            sbce_pkg::OP_AND:
            begin
                ex_wr   = 1'b1;
                ex_wval = p1_reg & p2_reg;
            end
            sbce_pkg::OP_ORR:
            begin
                ex_wr   = 1'b1;
                ex_wval = p1_reg | p2_reg;
            end
            sbce_pkg::OP_NOT:
            begin
                ex_wr   = 1'b1;
                ex_wval = ~p1_reg;
            end
            sbce_pkg::OP_XOR:
            begin
                ex_wr   = 1'b1;
                ex_wval = p1_reg ^ p2_reg;
            end
            sbce_pkg::OP_SHR:
            begin
                ex_wr   = 1'b1;
                ex_wval = sh[4] ? 16'h0000 : (p1_reg >> sh[3:0]);
            end
            sbce_pkg::OP_SHL:
            begin
                ex_wr   = 1'b1;
                ex_wval = sh[4] ? 16'h0000 : (p1_reg << sh[3:0]);
            end
            sbce_pkg::OP_ROR:
            begin
                ex_wr   = 1'b1;
                ex_wval = {p1_reg[0], p1_reg[15:1]};
            end
            sbce_pkg::OP_ROL:
            begin
                ex_wr   = 1'b1;
                ex_wval = {p1_reg[14:0], p1_reg[15]};
            end
            sbce_pkg::OP_HALT: ex_status = sbce_pkg::ST_HALT;
            default: ex_status = sbce_pkg::ST_UNDEFINED;
        endcase
    end

    always_comb
    begin
        if (ex_push)
            depth_next = depth_reg + 1'b1;
        else if (ex_pop)
            depth_next = depth_reg - 1'b1;
        else
            depth_next = depth_reg;
    end

    // ---------------- architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= 16'h0000;
            end_reg     <= 16'hFFFF;
            flags_reg   <= 4'h0;
            stopped_reg <= 1'b0;
            depth_reg   <= '0;
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= 16'h0000;
        end
        else if (cfg_we)
        begin
            case (sbce_pkg::cfg_index_t'(cfg_index))
                sbce_pkg::CFG_START: pc_reg  <= cfg_data;
                default:             end_reg <= cfg_data;
            endcase
        end
        else if (cmd.commit)
        begin
            if (ex_status != sbce_pkg::ST_OK)
                stopped_reg <= 1'b1;
            else
            begin
                pc_reg    <= ex_next;
                flags_reg <= ex_flags;
                depth_reg <= depth_next;
                if (ex_wr)
                    rf_reg[ra] <= ex_wval;
            end
        end
    end

    assign dstat.clr_last = clr_cnt_reg == CLR_LAST;
    assign dstat.stop_now = stopped_reg || (pc_reg > end_reg);
    assign dstat.is_ldr   = op == sbce_pkg::OP_LDR;
    assign dstat.is_mul   = op == sbce_pkg::OP_MUL;

    // ---------------- result registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pc            <= pc_reg;
            instruction   <= 16'h0000;
            status        <= sbce_pkg::ST_OK;
            reg_write     <= 1'b0;
            reg_index     <= 3'd0;
            reg_value     <= 16'h0000;
            flags         <= flags_reg;
            stack_pointer <= sbce_pkg::SP_BASE - (16'(depth_reg) << 1);
            read_data     <= 16'h0000;
            case (cmd.out_sel)
                sbce_pkg::OUT_READ:    read_data <= mem_data;
                sbce_pkg::OUT_STOPPED: status    <= sbce_pkg::ST_STOPPED;
                sbce_pkg::OUT_EXEC:
                begin
                    instruction <= instr_reg;
                    status      <= ex_status;
                    if (ex_status == sbce_pkg::ST_OK)
                    begin
                        reg_write     <= ex_wr;
                        reg_index     <= ex_wr ? ra : 3'd0;
                        reg_value     <= ex_wr ? ex_wval : 16'h0000;
                        flags         <= ex_flags;
                        stack_pointer <= sbce_pkg::SP_BASE - (16'(depth_next) << 1);
                    end
                end
                default: read_data <= 16'h0000;
            endcase
        end
    end

endmodule

>>> rtl/sixteen_bit_cpu_execute.sv
// sixteen_bit_cpu_execute: top level of the 16-bit execute block
// joins sbce_ctrl and sbce_dpath; depends on sbce_pkg
//
// After reset the block sweeps the word memory to zero, one word per cycle,
// and takes no transaction until the sweep ends (configuration writes are
// taken as ever). A load request is taken and answered from the idle state;
// a read adds a state for the single memory port. An execute request runs
// fetch, register read and execute, and LDR and MUL add a state for their
// second memory access or registered multiplier. A refused execute (stopped
// or past the end address) answers from the idle state. One transaction is
// worked at a time; a finished result waits in the output register until taken.
module sixteen_bit_cpu_execute #(
    parameter int MEM_WORDS   = sbce_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = sbce_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] address,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pc,
    output logic [15:0] instruction,
    output logic [2:0]  status,
    output logic        reg_write,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic [3:0]  flags,
    output logic [15:0] stack_pointer,
    output logic [15:0] read_data
);

    sbce_pkg::ctrl_cmd_t  cmd;
    sbce_pkg::dp_status_t dstat;

    sbce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dstat     (dstat),
        .cmd       (cmd)
    );

    sbce_dpath #(
        .MEM_WORDS   (MEM_WORDS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dstat         (dstat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .address       (address),
        .value         (value),
        .pc            (pc),
        .instruction   (instruction),
        .status        (status),
        .reg_write     (reg_write),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .flags         (flags),
        .stack_pointer (stack_pointer),
        .read_data     (read_data)
    );

endmodule

>>> bench/sbce_checker.sv
// sbce_checker: watches the request, result and configuration ports of the
// 16-bit execute block, predicts every result and compares it; uses sbce_pkg
`timescale 1ns / 1ps

module sbce_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] address,
    input  logic [15:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] pc,
    input  logic [15:0] instruction,
    input  logic [2:0]  status,
    input  logic        reg_write,
    input  logic [2:0]  reg_index,
    input  logic [15:0] reg_value,
    input  logic [3:0]  flags,
    input  logic [15:0] stack_pointer,
    input  logic [15:0] read_data,
    input  logic        end_check,
    output int          fail_count
);

    localparam int MEM_WORDS   = sbce_pkg::MEM_WORDS_DEF;
    localparam int STACK_DEPTH = sbce_pkg::STACK_DEPTH_DEF;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] instr;
        logic [2:0]  status;
        logic        rw;
        logic [2:0]  ridx;
        logic [15:0] rval;
        logic [3:0]  flags;
        logic [15:0] sp;
        logic [15:0] rdata;
    } cpu_result_t;

    cpu_result_t result_q[$];

    logic [15:0] mem_m[MEM_WORDS];
    logic [15:0] regs_m[8];
    logic [15:0] stk_m[STACK_DEPTH];
    logic [15:0] pc_m;
    logic [15:0] end_m;
    logic [3:0]  flg_m;
    int          depth_m;
    logic        stopped_m;
    logic        end_seen;
    int          fails = 0;

    assign fail_count = fails;

    function automatic logic [15:0] mem_rd(input logic [15:0] a);
        return (int'(a) < MEM_WORDS) ? mem_m[a] : 16'h0000;
    endfunction

    task automatic mem_wr(input logic [15:0] a, input logic [15:0] v);
        if (int'(a) < MEM_WORDS)
            mem_m[a] = v;
    endtask

    task automatic report(input string field, input logic [15:0] got,
                          input logic [15:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        fails++;
    endtask

    task automatic cpu_step(input logic [1:0] rq, input logic [15:0] ad,
                            input logic [15:0] vl);
        cpu_result_t e;
        logic [15:0] cur, nxt, ins, a, b, x, y, d, r, off, wval;
        logic [4:0]  op;
        logic [2:0]  ra, rb, rc, widx;
        logic [1:0]  sfx;
        logic [31:0] full;
        logic        c, ov, take, wr;
        logic [2:0]  st;
        e = '0;
        e.pc = pc_m;
        wr = 1'b0;
        widx = '0;
        wval = '0;
        st = sbce_pkg::ST_OK;
        case (rq)
            sbce_pkg::REQ_LOAD: mem_wr(ad, vl);
            sbce_pkg::REQ_READ: e.rdata = mem_rd(ad);
            sbce_pkg::REQ_EXEC:
            begin
                if (stopped_m || pc_m > end_m)
                begin
                    st = sbce_pkg::ST_STOPPED;
                end
                else
                begin
                    cur = pc_m;
                    nxt = cur + 16'd2;
                    ins = mem_rd(cur);
                    op = ins[15:11];
                    ra = ins[10:8];
                    rb = ins[7:5];
                    rc = ins[4:2];
                    sfx = ins[1:0];
                    a = regs_m[rb];
                    b = regs_m[rc];
                    case (op)
                        sbce_pkg::OP_SYS:
                        begin
                            if (sfx == sbce_pkg::SFX_PSH)
                            begin
                                if (depth_m >= STACK_DEPTH)
                                    st = sbce_pkg::ST_OVERFLOW;
                                else
                                begin
                                    stk_m[depth_m] = regs_m[ra];
                                    depth_m++;
                                end
                            end
                            else if (sfx == sbce_pkg::SFX_POP)
                            begin
                                if (depth_m == 0)
                                    st = sbce_pkg::ST_UNDERFLOW;
                                else
                                begin
                                    depth_m--;
                                    wr = 1'b1;
                                    widx = ra;
                                    wval = stk_m[depth_m];
                                end
                            end
                            else if (sfx == sbce_pkg::SFX_CMP)
                            begin
                                x = regs_m[ra];
                                y = regs_m[rb];
                                d = x - y;
                                flg_m = {x < y, 1'b0, x == y, d[15]};
                            end
                        end
                        sbce_pkg::OP_JMP:
                        begin
                            off = {{7{ins[10]}}, ins[10:2]};
                            take = (sfx == sbce_pkg::JC_ALWAYS) ||
                                   (sfx == sbce_pkg::JC_EQ && flg_m[1] && !flg_m[0]) ||
                                   (sfx == sbce_pkg::JC_LT && !flg_m[1] && flg_m[0]) ||
                                   (sfx == sbce_pkg::JC_GT && !flg_m[1] && !flg_m[0]);
                            if (take)
                                nxt = nxt + (off << 1);
                        end
                        sbce_pkg::OP_MOVR:
                        begin
                            wr = 1'b1; widx = ra; wval = a;
                        end
                        sbce_pkg::OP_MOVI:
                        begin
                            wr = 1'b1; widx = ra; wval = {8'h00, ins[7:0]};
                        end
                        sbce_pkg::OP_STRR: mem_wr(regs_m[ra], regs_m[rb]);
                        sbce_pkg::OP_STRI: mem_wr(regs_m[ra], {8'h00, ins[7:0]});
                        sbce_pkg::OP_LDR:
                        begin
                            wr = 1'b1; widx = ra; wval = mem_rd(a);
                        end
                        sbce_pkg::OP_ADD, sbce_pkg::OP_MUL:
                        begin
                            full = (op == sbce_pkg::OP_ADD) ? (32'(a) + 32'(b))
                                                            : (32'(a) * 32'(b));
                            c = full > 32'h0000_FFFF;
                            r = full[15:0];
                            if (c)
                                r = 16'h0000 - r;
                            if (op == sbce_pkg::OP_ADD)
                                ov = (a != 0 && !a[15] && b != 0 && !b[15] && r[15]) ||
                                     (a[15] && b[15] && !r[15]);
                            else
                                ov = c;
                            flg_m = {c, ov, r == 16'h0000, r[15]};
                            wr = 1'b1; widx = ra; wval = r;
                        end
                        sbce_pkg::OP_SUB:
                        begin
                            wr = 1'b1; widx = ra; wval = a - b;
                        end
                        sbce_pkg::OP_AND:
                        begin
                            wr = 1'b1; widx = ra; wval = a & b;
                        end
                        sbce_pkg::OP_ORR:
                        begin
                            wr = 1'b1; widx = ra; wval = a | b;
                        end
                        sbce_pkg::OP_NOT:
                        begin
                            wr = 1'b1; widx = ra; wval = ~a;
                        end
                        sbce_pkg::OP_XOR:
                        begin
                            wr = 1'b1; widx = ra; wval = a ^ b;
                        end
                        sbce_pkg::OP_SHR, sbce_pkg::OP_SHL:
                        begin
                            wr = 1'b1;
                            widx = ra;
                            if (ins[4])
                                wval = '0;
                            else if (op == sbce_pkg::OP_SHR)
                                wval = a >> ins[3:0];
                            else
                                wval = a << ins[3:0];
                        end
                        sbce_pkg::OP_ROR:
                        begin
                            wr = 1'b1; widx = ra; wval = {a[0], a[15:1]};
                        end
                        sbce_pkg::OP_ROL:
                        begin
                            wr = 1'b1; widx = ra; wval = {a[14:0], a[15]};
                        end
                        sbce_pkg::OP_HALT: st = sbce_pkg::ST_HALT;
                        default: st = sbce_pkg::ST_UNDEFINED;
                    endcase
                    e.pc = cur;
                    e.instr = ins;
                    if (st != sbce_pkg::ST_OK)
                        stopped_m = 1'b1;
                    else
                    begin
                        if (wr)
                            regs_m[widx] = wval;
                        pc_m = nxt;
                    end
                end
            end
            default: ;
        endcase
        e.status = st;
        e.rw = wr;
        e.ridx = wr ? widx : 3'd0;
        e.rval = wr ? wval : 16'h0000;
        e.flags = flg_m;
        e.sp = sbce_pkg::SP_BASE - 16'(2 * depth_m);
        result_q.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cpu_result_t w;
        if (!rst_n)
        begin
            foreach (mem_m[i]) mem_m[i] = '0;
            foreach (regs_m[i]) regs_m[i] = '0;
            foreach (stk_m[i]) stk_m[i] = '0;
            end_m = 16'hFFFF;
            pc_m = 16'h0000;
            flg_m = '0;
            depth_m = 0;
            stopped_m = 1'b0;
            end_seen = 1'b0;
            result_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sbce_pkg::CFG_START)
                    pc_m = cfg_data;
                else
                    end_m = cfg_data;
            end
            if (in_valid && in_ready)
                cpu_step(req_type, address, value);
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("result transaction with nothing expected, pc %h", pc);
                    fails++;
                end
                else
                begin
                    w = result_q.pop_front();
                    if (pc !== w.pc) report("pc", pc, w.pc);
                    if (instruction !== w.instr) report("instruction", instruction, w.instr);
                    if (status !== w.status) report("status", 16'(status), 16'(w.status));
                    if (reg_write !== w.rw) report("reg_write", 16'(reg_write), 16'(w.rw));
                    if (reg_index !== w.ridx) report("reg_index", 16'(reg_index), 16'(w.ridx));
                    if (reg_value !== w.rval) report("reg_value", reg_value, w.rval);
                    if (flags !== w.flags) report("flags", 16'(flags), 16'(w.flags));
                    if (stack_pointer !== w.sp) report("stack_pointer", stack_pointer, w.sp);
                    if (read_data !== w.rdata) report("read_data", read_data, w.rdata);
                end
            end
            if (end_check && !end_seen)
            begin
                end_seen = 1'b1;
                if (result_q.size() != 0)
                begin
                    $display("%0d expected results never arrived", result_q.size());
                    fails++;
                end
            end
        end
    end

endmodule

>>> bench/tb_sixteen_bit_cpu_execute.sv
// tb_sixteen_bit_cpu_execute: stimulus and verdict for the 16-bit execute
// block; runs short programs through it; needs sbce_pkg and sbce_checker
`timescale 1ns / 1ps

module tb_sixteen_bit_cpu_execute;

    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 1700;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [15:0] value;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] pc;
    logic [15:0] instruction;
    logic [2:0]  status;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  flags;
    logic [15:0] stack_pointer;
    logic [15:0] read_data;
    logic        end_check;
    int          fail_count;

    int sent_cnt;
    int recv_cnt = 0;
    int burst_left;
    int cyc = 0;
    int idle_cnt;

    sixteen_bit_cpu_execute dut (.*);

    sbce_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern: free, random, then periodic
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc / 600) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ((cyc % 7) < 3);
        endcase
        if (out_valid && out_ready)
            recv_cnt <= recv_cnt + 1;
    end

    initial
    begin
        idle_cnt = 0;
        while (idle_cnt < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
        end
        $display("sixteen_bit_cpu_execute test failed");
        $finish;
    end

    function automatic logic [15:0] enc(input logic [4:0] op, input logic [2:0] ra,
                                        input logic [2:0] rb, input logic [2:0] rc,
                                        input logic [1:0] sfx);
        return {op, ra, rb, rc, sfx};
    endfunction

    task automatic send(input logic [1:0] rq, input logic [15:0] ad, input logic [15:0] vl);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        address <= ad;
        value <= vl;
        do
            @(posedge clk);
        while (!in_ready);
        sent_cnt++;
        burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (recv_cnt != sent_cnt)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(input sbce_pkg::cfg_index_t idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // anything but stack ops, halt and undefined codes, so a program never stops
    function automatic logic [15:0] rand_instr();
        logic [4:0]  ops[17];
        logic [15:0] w;
        ops = '{sbce_pkg::OP_SYS, sbce_pkg::OP_JMP, sbce_pkg::OP_MOVR, sbce_pkg::OP_MOVI,
                sbce_pkg::OP_STRR, sbce_pkg::OP_STRI, sbce_pkg::OP_LDR, sbce_pkg::OP_ADD,
                sbce_pkg::OP_SUB, sbce_pkg::OP_MUL, sbce_pkg::OP_AND, sbce_pkg::OP_ORR,
                sbce_pkg::OP_NOT, sbce_pkg::OP_XOR, sbce_pkg::OP_SHR, sbce_pkg::OP_SHL,
                sbce_pkg::OP_ROR};
        w = 16'($urandom);
        w[15:11] = ($urandom_range(0, 17) == 17) ? sbce_pkg::OP_ROL
                                                 : ops[$urandom_range(0, 16)];
        if (w[15:11] == sbce_pkg::OP_SYS)
            w[1:0] = w[0] ? sbce_pkg::SFX_CMP : sbce_pkg::SFX_NOP;
        if (w[15:11] == sbce_pkg::OP_JMP && $urandom_range(0, 1))
            w[10:2] = 9'($signed($urandom_range(0, 16)) - 8);
        return w;
    endfunction

    task automatic noise();
        case ($urandom_range(0, 2))
            0: send(sbce_pkg::REQ_READ, 16'($urandom), 16'($urandom));
            1: send(sbce_pkg::REQ_LOAD, 16'($urandom) | 16'h0001, 16'($urandom));
            default: send(sbce_pkg::REQ_NONE, 16'($urandom), 16'($urandom));
        endcase
    endtask

    initial
    begin
        logic [15:0] prog[$];
        logic [15:0] base;
        int len;
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sbce_pkg::CFG_START;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = sbce_pkg::REQ_NONE;
        address = '0;
        value = '0;
        end_check = 1'b0;
        sent_cnt = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed program: every operation but MOVR, carry negation, big shifts, stack
        write_cfg(sbce_pkg::CFG_START, 16'h0010);
        write_cfg(sbce_pkg::CFG_END, 16'hFFFF);
        prog = '{enc(sbce_pkg::OP_MOVI, 3'd1, 3'd7, 3'd7, 2'd3),
                 enc(sbce_pkg::OP_MOVI, 3'd2, 3'd0, 3'd0, 2'd1),
                 enc(sbce_pkg::OP_SHL, 3'd4, 3'd1, 3'd2, 2'd0),
                 enc(sbce_pkg::OP_ADD, 3'd5, 3'd4, 3'd4, 2'd0),
                 enc(sbce_pkg::OP_MUL, 3'd6, 3'd4, 3'd4, 2'd0),
                 enc(sbce_pkg::OP_ADD, 3'd3, 3'd1, 3'd2, 2'd0),
                 enc(sbce_pkg::OP_SUB, 3'd3, 3'd2, 3'd1, 2'd0),
                 enc(sbce_pkg::OP_AND, 3'd3, 3'd4, 3'd1, 2'd0),
                 enc(sbce_pkg::OP_ORR, 3'd3, 3'd4, 3'd1, 2'd0),
                 enc(sbce_pkg::OP_NOT, 3'd3, 3'd0, 3'd0, 2'd0),
                 enc(sbce_pkg::OP_XOR, 3'd3, 3'd4, 3'd1, 2'd0),
                 enc(sbce_pkg::OP_SHR, 3'd3, 3'd4, 3'd4, 2'd0),
                 enc(sbce_pkg::OP_ROR, 3'd3, 3'd4, 3'd0, 2'd0),
                 enc(sbce_pkg::OP_ROL, 3'd3, 3'd4, 3'd0, 2'd0),
                 enc(sbce_pkg::OP_SYS, 3'd1, 3'd2, 3'd0, sbce_pkg::SFX_CMP),
                 enc(sbce_pkg::OP_JMP, 3'd0, 3'd0, 3'd0, sbce_pkg::JC_GT),
                 enc(sbce_pkg::OP_JMP, 3'd0, 3'd0, 3'd0, sbce_pkg::JC_EQ),
                 enc(sbce_pkg::OP_JMP, 3'd0, 3'd0, 3'd1, sbce_pkg::JC_ALWAYS),
                 16'hFFFF,
                 enc(sbce_pkg::OP_STRR, 3'd1, 3'd4, 3'd0, 2'd0),
                 enc(sbce_pkg::OP_STRI, 3'd2, 3'd5, 3'd2, 2'd1),
                 enc(sbce_pkg::OP_LDR, 3'd7, 3'd1, 3'd0, 2'd0),
                 enc(sbce_pkg::OP_SYS, 3'd1, 3'd0, 3'd0, sbce_pkg::SFX_PSH),
                 enc(sbce_pkg::OP_SYS, 3'd4, 3'd0, 3'd0, sbce_pkg::SFX_PSH),
                 enc(sbce_pkg::OP_SYS, 3'd7, 3'd0, 3'd0, sbce_pkg::SFX_POP),
                 enc(sbce_pkg::OP_SYS, 3'd0, 3'd0, 3'd0, sbce_pkg::SFX_POP),
                 enc(sbce_pkg::OP_SYS, 3'd2, 3'd1, 3'd0, sbce_pkg::SFX_CMP),
                 enc(sbce_pkg::OP_JMP, 3'd0, 3'd0, 3'd0, sbce_pkg::JC_LT)};
        foreach (prog[i])
            send(sbce_pkg::REQ_LOAD, 16'h0010 + 16'(2 * i), prog[i]);
        repeat (prog.size()) send(sbce_pkg::REQ_EXEC, '0, '0);
        send(sbce_pkg::REQ_READ, 16'h00FF, '0);
        send(sbce_pkg::REQ_LOAD, 16'hFFFF, 16'hFFFF);
        send(sbce_pkg::REQ_READ, 16'hFFFF, '0);
        send(sbce_pkg::REQ_NONE, 16'hFFFF, 16'hFFFF);
        wait_idle();
        // past the end address, then a fetch beyond memory that wraps
        write_cfg(sbce_pkg::CFG_END, 16'h0000);
        send(sbce_pkg::REQ_EXEC, '0, '0);
        wait_idle();
        write_cfg(sbce_pkg::CFG_START, 16'hFFFF);
        write_cfg(sbce_pkg::CFG_END, 16'hFFFF);
        repeat (3) send(sbce_pkg::REQ_EXEC, '0, '0);
        wait_idle();
        write_cfg(sbce_pkg::CFG_START, 16'h0000);
        repeat (2) send(sbce_pkg::REQ_EXEC, '0, '0);

        // random programs with random content
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            wait_idle();
            base = 16'($urandom_range(0, 2047)) << 1;
            len = $urandom_range(4, 24);
            write_cfg(sbce_pkg::CFG_START, base);
            write_cfg(sbce_pkg::CFG_END, ($urandom_range(0, 4) == 0) ?
                      base + 16'($urandom_range(0, 2 * len)) :
                      (($urandom_range(0, 5) == 0) ? 16'hFFFF : base + 16'(4 * len)));
            for (int i = 0; i < len; i++)
            begin
                send(sbce_pkg::REQ_LOAD, base + 16'(2 * i), rand_instr());
                n++;
                if ($urandom_range(0, 9) == 0)
                begin
                    noise();
                    n++;
                end
            end
            repeat (len + $urandom_range(0, 8))
            begin
                if ($urandom_range(0, 11) == 0)
                    noise();
                else
                    send(sbce_pkg::REQ_EXEC, '0, '0);
                n++;
            end
        end

        // finally overflow the stack, which stops execution for good
        wait_idle();
        write_cfg(sbce_pkg::CFG_START, 16'h0F00);
        write_cfg(sbce_pkg::CFG_END, 16'hFFFF);
        for (int i = 0; i < sbce_pkg::STACK_DEPTH_DEF + 1; i++)
            send(sbce_pkg::REQ_LOAD, 16'h0F00 + 16'(2 * i),
                 enc(sbce_pkg::OP_SYS, 3'($urandom), 3'd0, 3'd0, sbce_pkg::SFX_PSH));
        repeat (sbce_pkg::STACK_DEPTH_DEF + 3) send(sbce_pkg::REQ_EXEC, '0, '0);
        wait_idle();
        repeat (20) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("sixteen_bit_cpu_execute test passed");
        else
            $display("sixteen_bit_cpu_execute test failed");
        $finish;
    end

endmodule
